>>> src/threshold_crossing_interpolator_assert.svh
// assertion macros for the level crossing block
`ifndef THRESHOLD_CROSSING_INTERPOLATOR_ASSERT_SVH
`define THRESHOLD_CROSSING_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define TCI_ASSERT_IMPL(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCI_ASSERT_NEXT(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/tci_pkg.sv
package tci_pkg;

  // threshold after reset, 1.0 in q16.16
  localparam int unsigned THRESHOLD_RESET = 65536;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic mul_step;
    logic div_step;
    logic finish;
  } tci_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic iter_last;
  } tci_status_t;

endpackage

>>> src/tci_if.sv
// sample channel
interface tci_in_if #(parameter int DATA_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic        [DATA_WIDTH-1:0] x_value;
  logic signed [DATA_WIDTH-1:0] y_value;
  logic                         last_sample;

  modport source (output valid, output x_value, output y_value, output last_sample,
                  input ready);
  modport sink (input valid, input x_value, input y_value, input last_sample,
                output ready);
endinterface

// result channel
interface tci_out_if #(parameter int DATA_WIDTH = 32) ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] crossing_x;
  logic                  found;

  modport source (output valid, output crossing_x, output found, input ready);
  modport sink (input valid, input crossing_x, input found, output ready);
endinterface

>>> src/threshold_crossing_interpolator.sv
// a sample with no crossing does not hold off the next; the not-found result of a sweep is registered and
// shown in the cycle after its last sample is taken; a crossing sample holds off the next sample until done:
//   a shift-add multiply and a restoring divide, one bit per cycle each, then the result
// throughput: one sample per cycle outside that interpolation, while the result slot is not stalled
// synchronous rst clears the sweep state and the result slot, threshold returns to 1.0
`include "threshold_crossing_interpolator_assert.svh"

module threshold_crossing_interpolator
  import tci_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [DATA_WIDTH-1:0] cfg_data,
  tci_in_if.sink                sample_in,
  tci_out_if.source             result_out
);

  tci_cmd_t    cmd;
  tci_status_t status;
  logic        in_ready;
  logic        out_busy;

  // result slot still holds a beat that is not taken
  assign out_busy        = result_out.valid && !result_out.ready;
  assign sample_in.ready = in_ready;

  tci_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_in.valid),
    .out_busy (out_busy),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  tci_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .x_value     (sample_in.x_value),
    .y_value     (sample_in.y_value),
    .last_sample (sample_in.last_sample),
    .out_ready   (result_out.ready),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (result_out.valid),
    .crossing_x  (result_out.crossing_x),
    .found       (result_out.found)
  );

  // no-crossing beats carry a zero abscissa
  `TCI_ASSERT_IMPL(a_notfound_zero, clk, rst, result_out.valid && !result_out.found, result_out.crossing_x == '0, "not-found beat with nonzero abscissa")
  // no sample is taken while interpolating
  `TCI_ASSERT_IMPL(a_busy_no_ready, clk, rst, cmd.mul_step || cmd.div_step || cmd.finish, !in_ready, "sample taken during interpolation")
  // finishing always presents a found beat
  `TCI_ASSERT_NEXT(a_finish_found, clk, rst, cmd.finish, result_out.valid && result_out.found, "interpolation finished without a found beat")

endmodule

>>> src/tci_ctrl.sv
module tci_ctrl
  import tci_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        out_busy,
  input  tci_status_t status,
  output logic        in_ready,
  output tci_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_t;

  state_t state;

  // samples are taken only when idle and the result slot can take a beat
  assign in_ready = (state == S_IDLE) && !out_busy;

  always_comb begin
    cmd.accept   = in_valid && in_ready;
    cmd.mul_step = (state == S_MUL);
    cmd.div_step = (state == S_DIV);
    cmd.finish   = (state == S_FINISH);
  end

  // sequencer: multiply then divide, one bit per cycle each, then a finish state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.accept && status.hit) state <= S_MUL;
        end
        S_MUL: begin
          if (status.iter_last) state <= S_DIV;
        end
        S_DIV: begin
          if (status.iter_last) state <= S_FINISH;
        end
        S_FINISH: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/tci_datapath.sv
module tci_datapath
  import tci_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic        [DATA_WIDTH-1:0] cfg_data,
  input  logic        [DATA_WIDTH-1:0] x_value,
  input  logic signed [DATA_WIDTH-1:0] y_value,
  input  logic                         last_sample,
  input  logic                         out_ready,
  input  tci_cmd_t                     cmd,
  output tci_status_t                  status,
  output logic                         out_valid,
  output logic        [DATA_WIDTH-1:0] crossing_x,
  output logic                         found
);

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(DATA_WIDTH);
  localparam logic [W-1:0] THRESH_INIT = W'(THRESHOLD_RESET);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  logic signed [W-1:0] threshold;
  logic        [W-1:0] previous_x;
  logic signed [W-1:0] previous_y;
  logic                have_previous;
  logic                sweep_done;

  logic signed [W:0]   t_ext;
  logic signed [W:0]   py_ext;
  logic signed [W:0]   y_ext;
  logic signed [W:0]   num_diff;
  logic signed [W:0]   den_diff;
  logic        [W:0]   num_mag;
  logic        [W:0]   den_mag;
  logic                dx_up;
  logic        [W-1:0] dx;
  logic                crosses;

  logic [W:0]    num_r;
  logic [W:0]    den_r;
  logic [W-1:0]  base_x;
  logic          dir_down;
  logic [W+1:0]  acc_hi;
  logic [W-1:0]  acc_lo;
  logic [CW-1:0] cnt;

  logic [W+1:0]  mul_sum;
  logic [W:0]    rem_shift;
  logic          rem_ge;
  logic [W:0]    rem_sub;

  // crossing test against the previous sample
  always_comb begin
    crosses = ((previous_y >= threshold) && (y_value < threshold)) ||
              ((previous_y <= threshold) && (y_value > threshold));
    status.hit = have_previous && !sweep_done && crosses;
    status.iter_last = (cnt == CNT_LAST);
  end

  // interpolation operands: magnitudes and direction
  always_comb begin
    t_ext    = {threshold[W-1], threshold};
    py_ext   = {previous_y[W-1], previous_y};
    y_ext    = {y_value[W-1], y_value};
    num_diff = t_ext - py_ext;
    den_diff = y_ext - py_ext;
    num_mag  = num_diff[W] ? (W+1)'(0) - num_diff : num_diff;
    den_mag  = den_diff[W] ? (W+1)'(0) - den_diff : den_diff;
    dx_up    = (x_value >= previous_x);
    dx       = dx_up ? x_value - previous_x : previous_x - x_value;
  end

  // shift-add multiply and restoring divide steps
  always_comb begin
    mul_sum   = acc_hi + (acc_lo[0] ? {1'b0, num_r} : '0);
    rem_shift = {acc_hi[W-1:0], acc_lo[W-1]};
    rem_ge    = (rem_shift >= den_r);
    rem_sub   = rem_shift - den_r;
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_INIT;
    end else if (cfg_we) begin
      threshold <= cfg_data;
    end
  end

  // sweep state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_x    <= '0;
      previous_y    <= '0;
      have_previous <= 1'b0;
      sweep_done    <= 1'b0;
    end else if (cmd.accept) begin
      if (last_sample) begin
        previous_x    <= '0;
        previous_y    <= '0;
        have_previous <= 1'b0;
        sweep_done    <= 1'b0;
      end else if (!sweep_done) begin
        previous_x    <= x_value;
        previous_y    <= y_value;
        have_previous <= 1'b1;
        if (status.hit) sweep_done <= 1'b1;
      end
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.accept && status.hit) begin
      num_r    <= num_mag;
      den_r    <= den_mag;
      base_x   <= previous_x;
      dir_down <= !dx_up;
      acc_hi   <= '0;
      acc_lo   <= dx;
    end else if (cmd.mul_step) begin
      acc_hi <= {1'b0, mul_sum[W+1:1]};
      acc_lo <= {mul_sum[0], acc_lo[W-1:1]};
    end else if (cmd.div_step) begin
      acc_hi <= {1'b0, rem_ge ? rem_sub : rem_shift};
      acc_lo <= {acc_lo[W-2:0], rem_ge};
    end
  end

  // bit counter shared by both phases
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.accept && status.hit) begin
      cnt <= '0;
    end else if (cmd.mul_step || cmd.div_step) begin
      cnt <= status.iter_last ? '0 : cnt + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (cmd.accept && !sweep_done && !status.hit && last_sample) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      crossing_x <= dir_down ? base_x - acc_lo : base_x + acc_lo;
      found      <= 1'b1;
    end else if (cmd.accept && !sweep_done && !status.hit && last_sample) begin
      crossing_x <= '0;
      found      <= 1'b0;
    end
  end

endmodule

>>> bench/tb_threshold_crossing_interpolator.sv
`timescale 1ns / 100ps

module tb_threshold_crossing_interpolator;
  import tci_pkg::*;

  localparam int DW = 32;
  // longest interpolation plus some margin
  localparam int DRAIN_CYCLES = 2 * DW + 12;
  localparam int STALL_LIMIT = 4000;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int SQUEEZE_AFTER = 300;
  localparam int RANDOM_ITEMS = 1400;
  localparam int PHASE_ITEMS = 200;
  localparam logic [DW-1:0] LEVEL_MINUS_180 = 32'hFF4C_0000;
  localparam logic [DW-1:0] LEVEL_MIN = 32'h8000_0000;
  localparam logic [DW-1:0] LEVEL_MAX = 32'h7FFF_FFFF;
  localparam longint Y_MAX = 2147483647;
  localparam longint Y_MIN = -longint'(2147483647) - 1;

  typedef struct packed {
    logic [DW-1:0] crossing_x;
    logic          found;
  } crossing_t;

  typedef enum logic {ROW_SAMPLE, ROW_LEVEL} row_kind_e;
  typedef enum logic [1:0] {BY_MODEL, WANT_NONE, WANT_RESULT} row_check_e;

  // level rows carry the new threshold in the y column
  typedef struct packed {
    row_kind_e     kind;
    logic [DW-1:0] x;
    logic [DW-1:0] y;
    logic          last;
    row_check_e    check;
    logic [DW-1:0] want_x;
    logic          want_found;
  } row_t;

  row_t directed_rows [0:25] = '{
    // single-sample sweep at the reset level
    '{ROW_SAMPLE, 32'd100, 32'h0000_0000, 1'b1, WANT_RESULT, 32'd0, 1'b0},
    // rising crossing halfway, rest of the sweep ignored
    '{ROW_SAMPLE, 32'h0000_0000, 32'h0000_0000, 1'b0, WANT_NONE, 32'd0, 1'b0},
    '{ROW_SAMPLE, 32'h0002_0000, 32'h0002_0000, 1'b0, WANT_RESULT, 32'h0001_0000, 1'b1},
    '{ROW_SAMPLE, 32'h0003_0000, 32'hFFFF_0000, 1'b0, WANT_NONE, 32'd0, 1'b0},
    '{ROW_SAMPLE, 32'h0004_0000, 32'h0005_0000, 1'b1, WANT_NONE, 32'd0, 1'b0},
    // sweep that never reaches the level
    '{ROW_SAMPLE, 32'd5, 32'hFFFF_FFFB, 1'b0, WANT_NONE, 32'd0, 1'b0},
    '{ROW_SAMPLE, 32'd6, 32'hFFFF_FFFA, 1'b1, WANT_RESULT, 32'd0, 1'b0},
    // falling crossing on the last sample, x going down
    '{ROW_SAMPLE, 32'h0003_0000, 32'h0003_0000, 1'b0, WANT_NONE, 32'd0, 1'b0},
    '{ROW_SAMPLE, 32'h0001_0000, 32'hFFFF_0000, 1'b1, WANT_RESULT, 32'h0002_0000, 1'b1},
    // touching the level is no crossing, leaving it upward is
    '{ROW_SAMPLE, 32'd3, 32'h0000_8000, 1'b0, WANT_NONE, 32'd0, 1'b0},
    '{ROW_SAMPLE, 32'd7, 32'h0001_0000, 1'b0, WANT_NONE, 32'd0, 1'b0},
    '{ROW_SAMPLE, 32'd9, 32'h0001_0001, 1'b1, WANT_RESULT, 32'd7, 1'b1},
    // lowest level, start exactly on it
    '{ROW_LEVEL, 32'd0, LEVEL_MIN, 1'b0, WANT_NONE, 32'd0, 1'b0},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, WANT_NONE, 32'd0, 1'b0},
    '{ROW_SAMPLE, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, WANT_RESULT, 32'hFFFF_FFFF, 1'b1},
    // just under the highest level, widest span in x and y
    '{ROW_LEVEL, 32'd0, 32'h7FFF_FFFE, 1'b0, WANT_NONE, 32'd0, 1'b0},
    '{ROW_SAMPLE, 32'h0000_0000, 32'h8000_0000, 1'b0, WANT_NONE, 32'd0, 1'b0},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, BY_MODEL, 32'd0, 1'b0},
    // highest level, nothing can cross upward
    '{ROW_LEVEL, 32'd0, LEVEL_MAX, 1'b0, WANT_NONE, 32'd0, 1'b0},
    '{ROW_SAMPLE, 32'h1234_5678, 32'h8000_0000, 1'b0, WANT_NONE, 32'd0, 1'b0},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, WANT_RESULT, 32'd0, 1'b0},
    // phase level -180, moved to -150 within the sweep
    '{ROW_LEVEL, 32'd0, LEVEL_MINUS_180, 1'b0, WANT_NONE, 32'd0, 1'b0},
    '{ROW_SAMPLE, 32'h0001_0000, 32'hFF60_0000, 1'b0, WANT_NONE, 32'd0, 1'b0},
    '{ROW_LEVEL, 32'd0, 32'hFF6A_0000, 1'b0, WANT_NONE, 32'd0, 1'b0},
    '{ROW_SAMPLE, 32'h0002_8000, 32'hFF74_0000, 1'b0, BY_MODEL, 32'd0, 1'b0},
    '{ROW_SAMPLE, 32'h0003_0000, 32'h0000_0000, 1'b1, WANT_NONE, 32'd0, 1'b0}
  };

  logic          clk;
  logic          rst;
  logic          cfg_we;
  logic [DW-1:0] cfg_data;

  tci_in_if #(.DATA_WIDTH(DW)) sample_ch ();
  tci_out_if #(.DATA_WIDTH(DW)) result_ch ();

  // sweep tracker state
  logic signed [DW-1:0] level_q;
  logic [DW-1:0]        prev_x_q;
  logic signed [DW-1:0] prev_y_q;
  logic                 have_prev_q;
  logic                 sweep_closed_q;

  crossing_t pending_crossings[$];
  int errors = 0;
  int quiet_cycles = 0;
  bit squeeze_req = 1'b0;

  threshold_crossing_interpolator #(.DATA_WIDTH(DW)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .sample_in(sample_ch),
    .result_out(result_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // one sample through the sweep tracker; returns 1 when it yields a result
  function automatic bit predict_crossing(input logic [DW-1:0] x, input logic signed [DW-1:0] y,
                                          input logic last, output crossing_t res);
    longint lvl, py, cy;
    logic [63:0] num, den, dx, off;
    bit hit;
    res = '0;
    hit = 1'b0;
    if (!sweep_closed_q) begin
      lvl = longint'(level_q);
      py = longint'(prev_y_q);
      cy = longint'(y);
      if (have_prev_q && ((py >= lvl && cy < lvl) || (py <= lvl && cy > lvl))) begin
        num = (lvl >= py) ? lvl - py : py - lvl;
        den = (cy >= py) ? cy - py : py - cy;
        dx = (x >= prev_x_q) ? x - prev_x_q : prev_x_q - x;
        // offset truncates toward zero, then steps from the previous x
        off = num * dx / den;
        res.crossing_x = (x >= prev_x_q) ? prev_x_q + off[DW-1:0] : prev_x_q - off[DW-1:0];
        res.found = 1'b1;
        hit = 1'b1;
        sweep_closed_q = 1'b1;
      end else if (last) begin
        hit = 1'b1;
      end
      prev_x_q = x;
      prev_y_q = y;
      have_prev_q = 1'b1;
    end
    if (last) begin
      prev_x_q = '0;
      prev_y_q = '0;
      have_prev_q = 1'b0;
      sweep_closed_q = 1'b0;
    end
    return hit;
  endfunction

  // offer one sample after a gap, then record what it should produce
  task automatic push_sample(input logic [DW-1:0] x, input logic [DW-1:0] y, input logic last,
                             input int gap, input row_check_e check, input crossing_t want);
    crossing_t model;
    bit hit;
    @(negedge clk);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.x_value <= x;
    sample_ch.y_value <= y;
    sample_ch.last_sample <= last;
    do @(posedge clk); while (!sample_ch.ready);
    hit = predict_crossing(x, y, last, model);
    case (check)
      BY_MODEL: if (hit) pending_crossings = {pending_crossings, model};
      WANT_RESULT: pending_crossings = {pending_crossings, want};
      default: ;
    endcase
  endtask

  // stop offering, collect every pending result, let an interpolation finish
  task automatic drain_block();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (pending_crossings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_level(input logic [DW-1:0] value);
    drain_block();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    level_q = value;
  endtask

  // stimulus: directed table, then random sweeps in level phases
  initial begin : stimulus
    crossing_t want;
    row_t row;
    int sent, phase, len, style, gap, k;
    bit burst;
    logic [DW-1:0] x, y, step;
    longint lvl, delta, v;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.x_value = '0;
    sample_ch.y_value = '0;
    sample_ch.last_sample = 1'b0;
    level_q = THRESHOLD_RESET;
    prev_x_q = '0;
    prev_y_q = '0;
    have_prev_q = 1'b0;
    sweep_closed_q = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_LEVEL) begin
        write_level(row.y);
      end else begin
        want.crossing_x = row.want_x;
        want.found = row.want_found;
        push_sample(row.x, row.y, row.last, $urandom_range(0, 11), row.check, want);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      // new level at each phase boundary, fixed ones including the extremes, then random
      if (sent >= phase * PHASE_ITEMS) begin
        case (phase)
          0: write_level(THRESHOLD_RESET);
          1: write_level(LEVEL_MINUS_180);
          2: write_level('0);
          3: write_level(LEVEL_MIN);
          4: write_level(LEVEL_MAX);
          default: write_level($urandom);
        endcase
        phase++;
      end
      if (sent >= SQUEEZE_AFTER) squeeze_req = 1'b1;

      // mostly short sweeps around the level, some long, some noise
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
      style = $urandom_range(0, 9);
      burst = ($urandom_range(0, 3) == 0);
      x = $urandom;
      step = $urandom_range(1, 1 << $urandom_range(0, 20));
      lvl = longint'(level_q);
      for (int i = 0; i < len; i++) begin
        if (style == 0) begin
          x = $urandom;
          y = $urandom;
        end else begin
          x = x + step;
          k = $urandom_range(0, 31);
          delta = longint'($urandom) & ((longint'(1) << k) - 1);
          if (style == 1 || $urandom_range(0, 1) == 0) v = lvl + delta + 1;
          else v = lvl - delta - 1;
          if (style != 1 && $urandom_range(0, 7) == 0) v = lvl;
          if (v > Y_MAX) v = Y_MAX;
          if (v < Y_MIN) v = Y_MIN;
          y = v[DW-1:0];
        end
        gap = burst ? 0 : $urandom_range(0, 11);
        push_sample(x, y, (i == len - 1), gap, BY_MODEL, '0);
        sent++;
      end
    end

    drain_block();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // result side: random stalls, one long hold-off, field checks
  initial begin : result_sink
    crossing_t want;
    int stall;
    bit burst, held;
    burst = 1'b0;
    held = 1'b0;
    result_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (squeeze_req && !held) begin
        held = 1'b1;
        stall = SQUEEZE_CYCLES;
      end else begin
        if ($urandom_range(0, 15) == 0) burst = !burst;
        stall = burst ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      if (pending_crossings.size() == 0) begin
        $display("%0t unexpected result beat: expected none, got crossing_x %h found %b",
                 $time, result_ch.crossing_x, result_ch.found);
        errors++;
      end else begin
        want = pending_crossings.pop_front();
        if (result_ch.crossing_x !== want.crossing_x) begin
          $display("%0t crossing_x mismatch: expected %h, got %h", $time,
                   want.crossing_x, result_ch.crossing_x);
          errors++;
        end
        if (result_ch.found !== want.found) begin
          $display("%0t found mismatch: expected %b, got %b", $time,
                   want.found, result_ch.found);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

>>> filelist.f
+incdir+src
src/tci_pkg.sv
src/tci_if.sv
src/tci_ctrl.sv
src/tci_datapath.sv
src/threshold_crossing_interpolator.sv
bench/tb_threshold_crossing_interpolator.sv
